@@ sv/lsa_pkg.sv @@
package lsa_pkg;

   // fixed field widths
   localparam int SCORE_W = 14;
   localparam int REG_W = 8;
   localparam int SYM_W = 8;
   localparam int POS_W = 6;
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;

   // default capacities
   localparam int MAX_LEN_ONE_DEF = 32;
   localparam int MAX_LEN_TWO_DEF = 32;

   localparam logic [SYM_W-1:0] GAP_CODE = 8'd95;

   typedef enum logic [1:0] {
      FUNC_APPEND_ONE = 2'd0,
      FUNC_APPEND_TWO = 2'd1,
      FUNC_RUN        = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      REG_MATCH    = 2'd0,
      REG_MISMATCH = 2'd1,
      REG_GAP      = 2'd2
   } reg_index_type;

   typedef enum logic [1:0] {
      DIR_DIAG = 2'd0,
      DIR_UP   = 2'd1,
      DIR_LEFT = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      KIND_MATCH    = 2'd0,
      KIND_MISMATCH = 2'd1,
      KIND_GAP      = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_SCAN,
      ST_TB_READ,
      ST_TB_STEP,
      ST_EMPTY,
      ST_OUT_READ,
      ST_OUT_LOAD
   } state_type;

   // word handed from one cell to the next
   typedef struct packed {
      logic                       valid;
      logic [SYM_W-1:0]           sym;
      logic signed [SCORE_W-1:0]  score;
   } link_type;

   // one stored matrix entry
   typedef struct packed {
      dir_type                    dir;
      logic signed [SCORE_W-1:0]  score;
   } entry_type;

   // one alignment column
   typedef struct packed {
      kind_type          kind;
      logic [SYM_W-1:0]  bottom;
      logic [SYM_W-1:0]  top;
   } column_type;

   // scoring registers broadcast to the cells
   typedef struct packed {
      logic signed [REG_W-1:0] match;
      logic signed [REG_W-1:0] mismatch;
      logic signed [REG_W-1:0] gap;
   } scores_type;

   // add an 8-bit step to a score, saturating to the score range
   function automatic logic signed [SCORE_W-1:0] sat_add(
      input logic signed [SCORE_W-1:0] a,
      input logic signed [REG_W-1:0] b);
      logic signed [SCORE_W:0] s;
      logic signed [SCORE_W-1:0] r;
      s = {a[SCORE_W-1], a} + {{(SCORE_W + 1 - REG_W){b[REG_W-1]}}, b};
      if (s[SCORE_W] != s[SCORE_W-1]) begin
         r = s[SCORE_W] ? {1'b1, {(SCORE_W - 1){1'b0}}} : {1'b0, {(SCORE_W - 1){1'b1}}};
      end else begin
         r = s[SCORE_W-1:0];
      end
      return r;
   endfunction

endpackage

@@ sv/lsa_if.sv @@
interface lsa_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] symbol;

   modport source (output valid, func, symbol, input ready);
   modport sink (input valid, func, symbol, output ready);
endinterface

interface lsa_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        top_symbol;
   logic [7:0]        bottom_symbol;
   logic [1:0]        column_kind;
   logic signed [13:0] best_score;
   logic [5:0]        best_row;
   logic [5:0]        best_col;
   logic              empty_res;
   logic              last;

   modport source (output valid, top_symbol, bottom_symbol, column_kind, best_score,
                   best_row, best_col, empty_res, last, input ready);
   modport sink (input valid, top_symbol, bottom_symbol, column_kind, best_score,
                 best_row, best_col, empty_res, last, output ready);
endinterface

@@ sv/lsa_cell.sv @@
module lsa_cell #(
   parameter int MAX_LEN_ONE = lsa_pkg::MAX_LEN_ONE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   clear,
   input  logic                                   load_en,
   input  logic [lsa_pkg::SYM_W-1:0]              load_sym,
   input  lsa_pkg::scores_type                    scores,
   input  lsa_pkg::link_type                      link_in,
   input  logic [((MAX_LEN_ONE > 1) ? $clog2(MAX_LEN_ONE) : 1)-1:0] col_in,
   input  logic [((MAX_LEN_ONE > 1) ? $clog2(MAX_LEN_ONE) : 1)-1:0] rd_addr,
   output lsa_pkg::link_type                      link_out,
   output logic [((MAX_LEN_ONE > 1) ? $clog2(MAX_LEN_ONE) : 1)-1:0] col_out,
   output lsa_pkg::entry_type                     rd_data,
   output logic [lsa_pkg::SYM_W-1:0]              row_sym,
   output logic signed [lsa_pkg::SCORE_W-1:0]     row_best,
   output logic [((MAX_LEN_ONE > 1) ? $clog2(MAX_LEN_ONE) : 1)-1:0] row_best_col
);
   import lsa_pkg::*;

   localparam int A1_W = (MAX_LEN_ONE > 1) ? $clog2(MAX_LEN_ONE) : 1;

   logic [SYM_W-1:0]           row_sym_ff;
   logic signed [SCORE_W-1:0]  diag_ff;
   logic signed [SCORE_W-1:0]  left_ff;
   link_type                   link_ff;
   logic [A1_W-1:0]            col_ff;
   entry_type                  rd_ff;
   logic signed [SCORE_W-1:0]  best_ff;
   logic [A1_W-1:0]            best_col_ff;
   entry_type                  mem [MAX_LEN_ONE];

   logic [REG_W-1:0]           step;
   logic signed [SCORE_W-1:0]  diag_sc;
   logic signed [SCORE_W-1:0]  up_sc;
   logic signed [SCORE_W-1:0]  left_sc;
   entry_type                  cur;

   // cell rule: diagonal, up, left candidates with tie order
   always_comb begin
      step = (link_in.sym == row_sym_ff) ? scores.match : scores.mismatch;
      diag_sc = sat_add(diag_ff, step);
      up_sc = sat_add(link_in.score, scores.gap);
      left_sc = sat_add(left_ff, scores.gap);
      if (diag_sc >= up_sc) begin
         if (diag_sc >= left_sc) begin
            cur = '{dir: DIR_DIAG, score: diag_sc};
         end else begin
            cur = '{dir: DIR_LEFT, score: left_sc};
         end
      end else if (up_sc >= left_sc) begin
         cur = '{dir: DIR_UP, score: up_sc};
      end else begin
         cur = '{dir: DIR_LEFT, score: left_sc};
      end
   end

   // row symbol
   always_ff @(posedge clock) begin
      if (load_en) begin
         row_sym_ff <= load_sym;
      end
   end

   // neighbor scores, cleared at the start of a run
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         diag_ff <= '0;
         left_ff <= '0;
      end else if (link_in.valid) begin
         diag_ff <= link_in.score;
         left_ff <= cur.score;
      end
   end

   // hand the word to the next row
   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
      end
      link_ff.sym <= link_in.sym;
      link_ff.score <= cur.score;
      col_ff <= col_in;
   end

   // row memory of scores and directions
   always_ff @(posedge clock) begin
      if (link_in.valid) begin
         mem[col_in] <= cur;
      end
      rd_ff <= mem[rd_addr];
   end

   // first strict maximum along the row
   always_ff @(posedge clock) begin
      if (link_in.valid && ((col_in == '0) || (cur.score > best_ff))) begin
         best_ff <= cur.score;
         best_col_ff <= col_in;
      end
   end

   assign link_out = link_ff;
   assign col_out = col_ff;
   assign rd_data = rd_ff;
   assign row_sym = row_sym_ff;
   assign row_best = best_ff;
   assign row_best_col = best_col_ff;

endmodule

@@ sv/local_sequence_alignment.sv @@
// Local sequence aligner with linear gap scores. Symbols of append items
// (func 0 and 1) past the capacity are dropped. A run item streams sequence
// one through a chain of MAX_LEN_TWO cells, one cell per row of sequence
// two, to fill the matrix. The row maxima are then scanned, the traceback
// does a row memory read in every cell and then the step for each alignment
// column, and each result word is read back from the path buffer. The
// alignment words come out in forward order with best score and position on
// every word; a run with no alignment gives one word with empty_res set.
// Both lengths are cleared by every run. No new item is taken while a run
// is in progress.
module local_sequence_alignment #(
   parameter int MAX_LEN_ONE = lsa_pkg::MAX_LEN_ONE_DEF,
   parameter int MAX_LEN_TWO = lsa_pkg::MAX_LEN_TWO_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   lsa_req_if.sink                       req_chan,
   lsa_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [lsa_pkg::ADDR_W-1:0]    paddr,
   input  logic [lsa_pkg::DATA_W-1:0]    pwdata,
   output logic [lsa_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);
   import lsa_pkg::*;

   localparam int A1_W = (MAX_LEN_ONE > 1) ? $clog2(MAX_LEN_ONE) : 1;
   localparam int A2_W = (MAX_LEN_TWO > 1) ? $clog2(MAX_LEN_TWO) : 1;
   localparam int L1_W = $clog2(MAX_LEN_ONE + 1);
   localparam int L2_W = $clog2(MAX_LEN_TWO + 1);
   localparam int FC_W = $clog2(MAX_LEN_ONE + MAX_LEN_TWO + 2);
   localparam int P_D = MAX_LEN_ONE + MAX_LEN_TWO;
   localparam int P_W = $clog2(P_D);
   localparam int N_W = $clog2(P_D + 1);

   // configuration registers
   scores_type scores_ff;
   logic       cfg_wr;
   logic [1:0] cfg_idx;

   assign cfg_wr = psel && penable && pwrite;
   assign cfg_idx = paddr[3:2];
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scores_ff.match <= 8'sd1;
         scores_ff.mismatch <= -8'sd1;
         scores_ff.gap <= -8'sd2;
      end else if (cfg_wr) begin
         case (cfg_idx)
            REG_MATCH:    scores_ff.match <= pwdata[REG_W-1:0];
            REG_MISMATCH: scores_ff.mismatch <= pwdata[REG_W-1:0];
            REG_GAP:      scores_ff.gap <= pwdata[REG_W-1:0];
            default: ;
         endcase
      end
   end

   // register read back, sign extended
   always_comb begin
      case (cfg_idx)
         REG_MATCH:    prdata = DATA_W'(scores_ff.match);
         REG_MISMATCH: prdata = DATA_W'(scores_ff.mismatch);
         REG_GAP:      prdata = DATA_W'(scores_ff.gap);
         default:      prdata = '0;
      endcase
   end

   state_type state_ff, state_in;

   logic req_acc;
   logic run_start;
   logic app_one;
   logic app_two;

   logic [L1_W-1:0] len1_ff;
   logic [L2_W-1:0] len2_ff;
   logic [FC_W-1:0] fc_ff;
   logic            fill_done;
   logic            seq_empty;
   logic [A2_W-1:0] sc_ff;
   logic            scan_done;

   logic signed [SCORE_W-1:0] best_ff;
   logic [L2_W-1:0]           best_row_ff;
   logic [L1_W-1:0]           best_col_ff;
   logic [L2_W-1:0]           r_ff;
   logic [L1_W-1:0]           c_ff;
   logic [N_W-1:0]            n_ff;
   logic [N_W-1:0]            out_idx_ff;

   // sequence one store
   logic [SYM_W-1:0] seq1_mem [MAX_LEN_ONE];
   logic [SYM_W-1:0] seq1_rd_ff;
   logic [A1_W-1:0]  seq1_addr;
   logic [A1_W-1:0]  c_m1;

   // feed into the chain
   logic            feed_valid_ff;
   logic [A1_W-1:0] feed_col_ff;

   // chain signals
   link_type                   link_out [MAX_LEN_TWO];
   logic [A1_W-1:0]            col_out [MAX_LEN_TWO];
   entry_type                  cell_rd [MAX_LEN_TWO];
   logic [SYM_W-1:0]           cell_sym [MAX_LEN_TWO];
   logic signed [SCORE_W-1:0]  cell_best [MAX_LEN_TWO];
   logic [A1_W-1:0]            cell_best_col [MAX_LEN_TWO];

   // traceback step
   entry_type        tb_entry;
   logic [SYM_W-1:0] tb_a;
   logic [SYM_W-1:0] tb_b;
   logic             tb_r_dec;
   logic             tb_c_dec;
   logic             tb_zero;
   logic             tb_last;
   logic [N_W-1:0]   n_next;
   column_type       tb_col;

   // path buffer
   column_type path_mem [P_D];
   column_type path_rd_ff;

   // result register
   logic                      out_free;
   logic                      rsp_valid_ff;
   column_type                rsp_col_ff;
   logic                      rsp_empty_ff;
   logic                      rsp_last_ff;
   logic signed [SCORE_W-1:0] rsp_best_ff;
   logic [L2_W-1:0]           rsp_row_ff;
   logic [L1_W-1:0]           rsp_bcol_ff;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign run_start = req_acc && (req_chan.func == FUNC_RUN);
   assign app_one = req_acc && (req_chan.func == FUNC_APPEND_ONE);
   assign app_two = req_acc && (req_chan.func == FUNC_APPEND_TWO);
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign fill_done = (fc_ff == (FC_W'(len1_ff) + FC_W'(MAX_LEN_TWO + 1)));
   assign seq_empty = (len1_ff == '0) || (len2_ff == '0);
   assign scan_done = ((L2_W'(sc_ff) + L2_W'(1)) == len2_ff);
   assign c_m1 = A1_W'(c_ff - L1_W'(1));

   // traceback decode
   always_comb begin
      tb_entry = cell_rd[A2_W'(r_ff - L2_W'(1))];
      tb_a = seq1_rd_ff;
      tb_b = cell_sym[A2_W'(r_ff - L2_W'(1))];
      tb_zero = (tb_entry.score == '0);
      case (tb_entry.dir)
         DIR_DIAG: begin
            tb_r_dec = 1'b1;
            tb_c_dec = 1'b1;
            tb_col = '{kind: (tb_a == tb_b) ? KIND_MATCH : KIND_MISMATCH,
                       bottom: tb_b, top: tb_a};
         end
         DIR_LEFT: begin
            tb_r_dec = 1'b0;
            tb_c_dec = 1'b1;
            tb_col = '{kind: KIND_GAP, bottom: GAP_CODE, top: tb_a};
         end
         default: begin
            tb_r_dec = 1'b1;
            tb_c_dec = 1'b0;
            tb_col = '{kind: KIND_GAP, bottom: tb_b, top: GAP_CODE};
         end
      endcase
      tb_last = tb_zero || (tb_r_dec && (r_ff == L2_W'(1)))
                || (tb_c_dec && (c_ff == L1_W'(1)));
      n_next = tb_zero ? n_ff : n_ff + N_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (run_start) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (fill_done) state_in = seq_empty ? ST_EMPTY : ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_done) state_in = ST_TB_READ;
         end
         ST_TB_READ: state_in = ST_TB_STEP;
         ST_TB_STEP: begin
            if (tb_last) begin
               state_in = (n_next == '0) ? ST_EMPTY : ST_OUT_READ;
            end else begin
               state_in = ST_TB_READ;
            end
         end
         ST_EMPTY: begin
            if (out_free) state_in = ST_IDLE;
         end
         ST_OUT_READ: state_in = ST_OUT_LOAD;
         ST_OUT_LOAD: begin
            if (out_free) state_in = (out_idx_ff == '0) ? ST_IDLE : ST_OUT_READ;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      seq1_addr = (state_ff == ST_FILL) ? fc_ff[A1_W-1:0] : c_m1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // lengths
   always_ff @(posedge clock) begin
      if (reset || (state_ff == ST_EMPTY) || (state_ff == ST_OUT_READ)) begin
         len1_ff <= '0;
         len2_ff <= '0;
      end else begin
         if (app_one && (len1_ff < L1_W'(MAX_LEN_ONE))) len1_ff <= len1_ff + L1_W'(1);
         if (app_two && (len2_ff < L2_W'(MAX_LEN_TWO))) len2_ff <= len2_ff + L2_W'(1);
      end
   end

   // sequence one store
   always_ff @(posedge clock) begin
      if (app_one && (len1_ff < L1_W'(MAX_LEN_ONE))) begin
         seq1_mem[len1_ff[A1_W-1:0]] <= req_chan.symbol;
      end
      seq1_rd_ff <= seq1_mem[seq1_addr];
   end

   // fill counter and chain feed
   always_ff @(posedge clock) begin
      if (reset) begin
         feed_valid_ff <= 1'b0;
      end else begin
         feed_valid_ff <= (state_ff == ST_FILL) && (fc_ff < FC_W'(len1_ff));
      end
      feed_col_ff <= fc_ff[A1_W-1:0];
      if (run_start) begin
         fc_ff <= '0;
      end else if (state_ff == ST_FILL) begin
         fc_ff <= fc_ff + FC_W'(1);
      end
   end

   // row maxima scan, traceback position and path count
   always_ff @(posedge clock) begin
      if (run_start) begin
         best_ff <= '0;
         best_row_ff <= L2_W'(1);
         best_col_ff <= L1_W'(1);
         sc_ff <= '0;
         n_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         if ((sc_ff == '0) || (cell_best[sc_ff] > best_ff)) begin
            best_ff <= cell_best[sc_ff];
            best_row_ff <= L2_W'(sc_ff) + L2_W'(1);
            best_col_ff <= L1_W'(cell_best_col[sc_ff]) + L1_W'(1);
         end
         sc_ff <= sc_ff + A2_W'(1);
      end
      if ((state_ff == ST_SCAN) && ((sc_ff == '0) || (cell_best[sc_ff] > best_ff))) begin
         r_ff <= L2_W'(sc_ff) + L2_W'(1);
         c_ff <= L1_W'(cell_best_col[sc_ff]) + L1_W'(1);
      end else if (state_ff == ST_TB_STEP) begin
         if (tb_r_dec) r_ff <= r_ff - L2_W'(1);
         if (tb_c_dec) c_ff <= c_ff - L1_W'(1);
      end
      if (state_ff == ST_TB_STEP) begin
         n_ff <= n_next;
         out_idx_ff <= n_next - N_W'(1);
      end else if ((state_ff == ST_OUT_LOAD) && out_free) begin
         out_idx_ff <= out_idx_ff - N_W'(1);
      end
   end

   // path buffer
   always_ff @(posedge clock) begin
      if ((state_ff == ST_TB_STEP) && !tb_zero) begin
         path_mem[n_ff[P_W-1:0]] <= tb_col;
      end
      path_rd_ff <= path_mem[out_idx_ff[P_W-1:0]];
   end

   // result register, best score and position held with the word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == ST_EMPTY || state_ff == ST_OUT_LOAD) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if ((state_ff == ST_EMPTY) && out_free) begin
         rsp_col_ff <= '{kind: KIND_MATCH, bottom: '0, top: '0};
         rsp_empty_ff <= 1'b1;
         rsp_last_ff <= 1'b1;
         rsp_best_ff <= best_ff;
         rsp_row_ff <= best_row_ff;
         rsp_bcol_ff <= best_col_ff;
      end else if ((state_ff == ST_OUT_LOAD) && out_free) begin
         rsp_col_ff <= path_rd_ff;
         rsp_empty_ff <= 1'b0;
         rsp_last_ff <= (out_idx_ff == '0);
         rsp_best_ff <= best_ff;
         rsp_row_ff <= best_row_ff;
         rsp_bcol_ff <= best_col_ff;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.top_symbol = rsp_col_ff.top;
   assign rsp_chan.bottom_symbol = rsp_col_ff.bottom;
   assign rsp_chan.column_kind = rsp_col_ff.kind;
   assign rsp_chan.best_score = rsp_best_ff;
   assign rsp_chan.best_row = POS_W'(rsp_row_ff);
   assign rsp_chan.best_col = POS_W'(rsp_bcol_ff);
   assign rsp_chan.empty_res = rsp_empty_ff;
   assign rsp_chan.last = rsp_last_ff;

   // chain of row cells
   for (genvar i = 0; i < MAX_LEN_TWO; i++) begin : g_row
      link_type        link_in;
      logic [A1_W-1:0] col_in;
      logic            load_en;

      if (i == 0) begin : g_head
         assign link_in = '{valid: feed_valid_ff, sym: seq1_rd_ff, score: '0};
         assign col_in = feed_col_ff;
      end else begin : g_body
         assign link_in = link_out[i-1];
         assign col_in = col_out[i-1];
      end

      assign load_en = app_two && (len2_ff == L2_W'(i));

      lsa_cell #(
         .MAX_LEN_ONE(MAX_LEN_ONE)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .clear        (run_start),
         .load_en      (load_en),
         .load_sym     (req_chan.symbol),
         .scores       (scores_ff),
         .link_in      (link_in),
         .col_in       (col_in),
         .rd_addr      (c_m1),
         .link_out     (link_out[i]),
         .col_out      (col_out[i]),
         .rd_data      (cell_rd[i]),
         .row_sym      (cell_sym[i]),
         .row_best     (cell_best[i]),
         .row_best_col (cell_best_col[i])
      );
   end

endmodule
